>>> rtl/blasp_pkg.sv
package blasp_pkg;

  // parse phase codes
  localparam logic [1:0] PH_LEN     = 2'd0;
  localparam logic [1:0] PH_TYPE    = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_STOP    = 2'd3;

  // outcome codes
  localparam logic [1:0] OUT_OK        = 2'd0;
  localparam logic [1:0] OUT_MALFORMED = 2'd1;
  localparam logic [1:0] OUT_NONE      = 2'd2;

  localparam logic [7:0]  MFR_TYPE     = 8'hFF;
  localparam logic [3:0]  REC_BYTES    = 4'd9;
  localparam logic [7:0]  STATUS_A     = 8'd8;
  localparam logic [7:0]  STATUS_B     = 8'd6;
  localparam logic [15:0] HUMIDITY_MAX = 16'd10000;
  localparam logic [7:0]  BATTERY_MAX  = 8'd100;

  // record byte positions within the manufacturer payload
  localparam logic [3:0] POS_TEMP_LO = 4'd0;
  localparam logic [3:0] POS_TEMP_HI = 4'd1;
  localparam logic [3:0] POS_HUM_LO  = 4'd2;
  localparam logic [3:0] POS_HUM_HI  = 4'd3;
  localparam logic [3:0] POS_SEL     = 4'd4;
  localparam logic [3:0] POS_BATT    = 4'd7;
  localparam logic [3:0] POS_STATUS  = 4'd8;

  typedef struct packed {
    logic [7:0] adv_byte;
    logic       final_byte;
  } adv_item_t;

  typedef struct packed {
    logic [1:0]         outcome;
    logic               from_probe;
    logic signed [15:0] temperature_hundredths;
    logic [13:0]        humidity_hundredths;
    logic [6:0]         battery_level;
  } result_item_t;

endpackage

>>> rtl/ble_adv_sensor_record_parser_unit.sv
// Advertisement sensor record parser.
// Input channel adv_valid / adv_stall / adv_item carries one advertisement
// byte per item, with final_byte set on the last byte of the advertisement.
// Output channel result_valid / result_stall / result_item carries one item
// per advertisement: outcome (recognized, malformed, no supported data) and,
// when recognized, probe flag, temperature, humidity and battery.
// A final byte accepted goes into the input register, then the parse step
// moves its result into the result register, waiting while the result
// register is still stalled. Throughput: one byte per cycle, but a final
// byte waits on a stalled result; the parse step is a single short update
// of the structure counter and record captures between two registers.
// Reset (rst, synchronous) empties both registers and returns the parser
// to expecting a length byte. A stalled result holds; non-final bytes keep
// flowing under a stall, and a final byte waits in the input register until
// the result register frees, which then backs up adv_stall.
module ble_adv_sensor_record_parser_unit (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv_valid,
  output logic                    adv_stall,
  input  blasp_pkg::adv_item_t    adv_item,
  output logic                    result_valid,
  input  logic                    result_stall,
  output blasp_pkg::result_item_t result_item
);
  import blasp_pkg::*;

  logic         hold_valid;
  adv_item_t    hold_item;
  logic         out_ready;
  logic         advance;
  logic         take;
  result_item_t step_result;

  // byte in the input register moves on unless it is final and the slot is busy
  assign advance   = hold_valid && (!hold_item.final_byte || out_ready);
  assign adv_stall = hold_valid && !advance;
  assign take      = adv_valid && !adv_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_item <= adv_item;
    end
  end

  blasp_parse u_parse (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (hold_item),
    .result (step_result)
  );

  blasp_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && hold_item.final_byte),
    .load_item (step_result),
    .ready     (out_ready),
    .valid     (result_valid),
    .stall     (result_stall),
    .item      (result_item)
  );

endmodule

>>> rtl/blasp_parse.sv
module blasp_parse (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  blasp_pkg::adv_item_t  item,
  output blasp_pkg::result_item_t result
);
  import blasp_pkg::*;

  logic [1:0]  phase;
  logic [7:0]  bytes_left;
  logic        is_mfr;
  logic [3:0]  pos;
  logic [15:0] temp_cap;
  logic [15:0] hum_cap;
  logic [7:0]  sel_cap;
  logic [7:0]  batt_cap;
  logic [7:0]  status_cap;
  logic        match_done;

  logic [1:0]  phase_next;
  logic [7:0]  bytes_left_next;
  logic        is_mfr_next;
  logic [3:0]  pos_next;
  logic [15:0] temp_cap_next;
  logic [15:0] hum_cap_next;
  logic [7:0]  sel_cap_next;
  logic [7:0]  batt_cap_next;
  logic [7:0]  status_cap_next;
  logic        match_done_next;
  logic        finish;
  logic        rec_ok;
  logic [7:0]  b;

  assign b = item.adv_byte;

  // record checks, on the captures as they stand after this byte
  assign rec_ok = is_mfr_next && (pos_next >= REC_BYTES) &&
                  ((status_cap_next == STATUS_A) || (status_cap_next == STATUS_B)) &&
                  (sel_cap_next <= 8'd1) &&
                  (hum_cap_next <= HUMIDITY_MAX) &&
                  (batt_cap_next <= BATTERY_MAX);

  // per-byte structure walk
  always_comb begin
    phase_next      = phase;
    bytes_left_next = bytes_left;
    is_mfr_next     = is_mfr;
    pos_next        = pos;
    temp_cap_next   = temp_cap;
    hum_cap_next    = hum_cap;
    sel_cap_next    = sel_cap;
    batt_cap_next   = batt_cap;
    status_cap_next = status_cap;
    finish          = 1'b0;
    unique case (phase)
      PH_LEN: begin
        if (b == 8'd0) begin
          phase_next = PH_STOP;
        end else begin
          bytes_left_next = b;
          phase_next      = PH_TYPE;
        end
      end
      PH_TYPE: begin
        is_mfr_next     = (b == MFR_TYPE);
        pos_next        = 4'd0;
        bytes_left_next = bytes_left - 8'd1;
        if (bytes_left_next == 8'd0) begin
          finish = 1'b1;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (pos < REC_BYTES) begin
          unique case (pos)
            POS_TEMP_LO: temp_cap_next[7:0]  = b;
            POS_TEMP_HI: temp_cap_next[15:8] = b;
            POS_HUM_LO:  hum_cap_next[7:0]   = b;
            POS_HUM_HI:  hum_cap_next[15:8]  = b;
            POS_SEL:     sel_cap_next        = b;
            POS_BATT:    batt_cap_next       = b;
            POS_STATUS:  status_cap_next     = b;
            default:     ;
          endcase
          pos_next = pos + 4'd1;
        end
        bytes_left_next = bytes_left - 8'd1;
        if (bytes_left_next == 8'd0) begin
          finish = 1'b1;
        end
      end
      default: ;
    endcase
    match_done_next = match_done;
    if (finish) begin
      if (rec_ok) begin
        match_done_next = 1'b1;
        phase_next      = PH_STOP;
      end else begin
        phase_next = PH_LEN;
      end
    end
  end

  // result for a final byte
  always_comb begin
    result = '0;
    if (match_done_next) begin
      result.outcome                = OUT_OK;
      result.from_probe             = (sel_cap_next == 8'd1);
      result.temperature_hundredths = temp_cap_next;
      result.humidity_hundredths    = hum_cap_next[13:0];
      result.battery_level          = batt_cap_next[6:0];
    end else if ((phase_next == PH_TYPE) || (phase_next == PH_PAYLOAD)) begin
      result.outcome = OUT_MALFORMED;
    end else begin
      result.outcome = OUT_NONE;
    end
  end

  // control state, back to idle after each advertisement
  always_ff @(posedge clk) begin
    if (rst || (step && item.final_byte)) begin
      phase      <= PH_LEN;
      bytes_left <= 8'd0;
      is_mfr     <= 1'b0;
      pos        <= 4'd0;
      match_done <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      bytes_left <= bytes_left_next;
      is_mfr     <= is_mfr_next;
      pos        <= pos_next;
      match_done <= match_done_next;
    end
  end

  // record captures
  always_ff @(posedge clk) begin
    if (step) begin
      temp_cap   <= temp_cap_next;
      hum_cap    <= hum_cap_next;
      sel_cap    <= sel_cap_next;
      batt_cap   <= batt_cap_next;
      status_cap <= status_cap_next;
    end
  end

endmodule

>>> rtl/blasp_out.sv
module blasp_out (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  blasp_pkg::result_item_t load_item,
  output logic                    ready,
  output logic                    valid,
  input  logic                    stall,
  output blasp_pkg::result_item_t item
);
  import blasp_pkg::*;

  // slot can take a new item when empty or being drained this cycle
  assign ready = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= load_item;
    end
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import blasp_pkg::*;

  localparam int DIR_N       = 27;
  localparam int CYCLE_LIMIT = 400000;

  logic         clk          = 1'b0;
  logic         rst          = 1'b1;
  logic         adv_valid    = 1'b0;
  logic         adv_stall;
  adv_item_t    adv_item     = '0;
  logic         result_valid;
  logic         result_stall = 1'b0;
  result_item_t result_item;

  ble_adv_sensor_record_parser_unit dut (
    .clk          (clk),
    .rst          (rst),
    .adv_valid    (adv_valid),
    .adv_stall    (adv_stall),
    .adv_item     (adv_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

  always #5 clk = ~clk;

  // parser shadow state
  logic [1:0]  ph        = PH_LEN;
  logic [7:0]  left_cnt  = '0;
  logic        mfr_seen  = 1'b0;
  logic [3:0]  rec_pos   = '0;
  logic [15:0] temp_cap  = '0;
  logic [15:0] hum_cap   = '0;
  logic [7:0]  sel_cap   = '0;
  logic [7:0]  batt_cap  = '0;
  logic [7:0]  stat_cap  = '0;
  logic        matched   = 1'b0;

  // expected reports, oldest first
  result_item_t report_q[$];

  // typed-in report for the item currently offered
  logic         pin_on   = 1'b0;
  result_item_t pin_want = '0;

  // directed table
  logic [8:0]   dir_rows [DIR_N];
  result_item_t dir_want [5];

  logic [7:0] adv_bytes[$];

  int bytes_sent  = 0;
  int fault_cnt   = 0;
  int n_ok        = 0;
  int n_malformed = 0;
  int n_none      = 0;
  int cycle_cnt   = 0;

  // idling control shared by sender and receiver
  bit tx_calm   = 1'b0;
  bit rx_calm   = 1'b0;
  int took_cnt  = 0;
  int took_seen = 0;
  int hold_seq  = 0;
  int hold_seen = 0;
  int hold_len  = 0;
  int stall_left = 0;

  function automatic result_item_t report_of(logic [1:0] oc, logic probe, logic [15:0] temp,
                                             logic [13:0] hum, logic [6:0] batt);
    result_item_t r;
    r.outcome                = oc;
    r.from_probe             = probe;
    r.temperature_hundredths = temp;
    r.humidity_hundredths    = hum;
    r.battery_level          = batt;
    return r;
  endfunction

  function automatic void clear_parser();
    ph       = PH_LEN;
    left_cnt = '0;
    mfr_seen = 1'b0;
    rec_pos  = '0;
    temp_cap = '0;
    hum_cap  = '0;
    sel_cap  = '0;
    batt_cap = '0;
    stat_cap = '0;
    matched  = 1'b0;
  endfunction

  // a structure is complete: latch it if it holds a valid sensor record
  function automatic void close_structure();
    if (mfr_seen && rec_pos >= REC_BYTES && (stat_cap == STATUS_A || stat_cap == STATUS_B) &&
        sel_cap <= 8'd1 && hum_cap <= HUMIDITY_MAX && batt_cap <= BATTERY_MAX) begin
      matched = 1'b1;
      ph      = PH_STOP;
    end else begin
      ph = PH_LEN;
    end
  endfunction

  // advance the shadow parser by one byte; returns 1 with the report on a final byte
  function automatic bit predict_report(input adv_item_t it, output result_item_t r);
    logic [7:0] b;
    b = it.adv_byte;
    r = '0;
    case (ph)
      PH_LEN: begin
        if (b == 8'd0) begin
          ph = PH_STOP;
        end else begin
          left_cnt = b;
          ph       = PH_TYPE;
        end
      end
      PH_TYPE: begin
        mfr_seen = (b == MFR_TYPE);
        rec_pos  = '0;
        left_cnt = left_cnt - 8'd1;
        if (left_cnt == 8'd0) close_structure();
        else ph = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (rec_pos < REC_BYTES) begin
          case (rec_pos)
            POS_TEMP_LO: temp_cap[7:0]  = b;
            POS_TEMP_HI: temp_cap[15:8] = b;
            POS_HUM_LO:  hum_cap[7:0]   = b;
            POS_HUM_HI:  hum_cap[15:8]  = b;
            POS_SEL:     sel_cap        = b;
            POS_BATT:    batt_cap       = b;
            POS_STATUS:  stat_cap       = b;
            default: ;
          endcase
          rec_pos = rec_pos + 4'd1;
        end
        left_cnt = left_cnt - 8'd1;
        if (left_cnt == 8'd0) close_structure();
      end
      default: ;
    endcase
    if (!it.final_byte) return 1'b0;
    if (matched) begin
      r.outcome                = OUT_OK;
      r.from_probe             = (sel_cap == 8'd1);
      r.temperature_hundredths = temp_cap;
      r.humidity_hundredths    = hum_cap[13:0];
      r.battery_level          = batt_cap[6:0];
    end else if (ph == PH_TYPE || ph == PH_PAYLOAD) begin
      r.outcome = OUT_MALFORMED;
    end else begin
      r.outcome = OUT_NONE;
    end
    clear_parser();
    return 1'b1;
  endfunction

  // compare one accepted report with the oldest expectation
  function automatic void check_report(input result_item_t got);
    result_item_t want;
    if (report_q.size() == 0) begin
      $error("report with no expectation waiting: outcome %0d", got.outcome);
      fault_cnt++;
      return;
    end
    want = report_q.pop_front();
    case (want.outcome)
      OUT_OK:        n_ok++;
      OUT_MALFORMED: n_malformed++;
      default:       n_none++;
    endcase
    if (got.outcome !== want.outcome) begin
      $error("outcome: expected %0d, got %0d", want.outcome, got.outcome);
      fault_cnt++;
    end
    if (got.from_probe !== want.from_probe) begin
      $error("from_probe: expected %0d, got %0d", want.from_probe, got.from_probe);
      fault_cnt++;
    end
    if (got.temperature_hundredths !== want.temperature_hundredths) begin
      $error("temperature_hundredths: expected %0d, got %0d",
             want.temperature_hundredths, got.temperature_hundredths);
      fault_cnt++;
    end
    if (got.humidity_hundredths !== want.humidity_hundredths) begin
      $error("humidity_hundredths: expected %0d, got %0d",
             want.humidity_hundredths, got.humidity_hundredths);
      fault_cnt++;
    end
    if (got.battery_level !== want.battery_level) begin
      $error("battery_level: expected %0d, got %0d", want.battery_level, got.battery_level);
      fault_cnt++;
    end
  endfunction

  // sample both channels at the rising edge
  always @(posedge clk) begin : monitor
    result_item_t exp_r;
    if (!rst) begin
      if (adv_valid && !adv_stall) begin
        if (predict_report(adv_item, exp_r)) report_q.push_back(pin_on ? pin_want : exp_r);
      end
      if (result_valid && !result_stall) begin
        check_report(result_item);
        took_cnt++;
      end
    end
  end

  // receiver: per-report wait, or a long hold-off on request
  always @(negedge clk) begin
    if (took_cnt != took_seen) begin
      took_seen  = took_cnt;
      stall_left = rx_calm ? 0 : $urandom_range(0, 15);
    end
    if (hold_seq != hold_seen) begin
      hold_seen  = hold_seq;
      stall_left = hold_len;
    end
    result_stall = (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  // watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("watchdog expired after %0d cycles", cycle_cnt);
    $display("status: fail");
    $finish;
  end

  function automatic int draw_gap();
    return tx_calm ? 0 : $urandom_range(0, 15);
  endfunction

  // offer one byte after a gap, return at the falling edge after it is taken
  task automatic push_byte(input adv_item_t it, input int gap, input bit pin,
                           input result_item_t want);
    if (gap > 0) begin
      adv_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    adv_item  = it;
    pin_on    = pin;
    pin_want  = want;
    adv_valid = 1'b1;
    @(posedge clk);
    while (adv_stall) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_advert();
    adv_item_t it;
    for (int i = 0; i < adv_bytes.size(); i++) begin
      it.adv_byte   = adv_bytes[i];
      it.final_byte = (i == adv_bytes.size() - 1);
      push_byte(it, draw_gap(), 1'b0, '0);
    end
  endtask

  // random advertisement: mostly well-formed sensor records, some noise and breakage
  task automatic build_advert();
    int          kind;
    int          n_struct;
    int          plen;
    int          pick;
    int          keep;
    logic [15:0] temp;
    logic [15:0] hum;
    logic [7:0]  sel;
    logic [7:0]  batt;
    logic [7:0]  stat;
    logic [7:0]  b;
    adv_bytes.delete();
    kind = $urandom_range(0, 99);
    // pure noise
    if (kind < 5) begin
      repeat ($urandom_range(1, 20)) adv_bytes.push_back(8'($urandom));
      return;
    end
    n_struct = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(1, 2);
    repeat (n_struct) begin
      if ($urandom_range(0, 99) < 60) begin
        // manufacturer record, mostly nine payload bytes
        pick = $urandom_range(0, 99);
        if (pick < 80) plen = 9;
        else if (pick < 90) plen = $urandom_range(10, 20);
        else if (pick < 97) plen = $urandom_range(0, 8);
        else plen = ($urandom_range(0, 1) == 0) ? 254 : $urandom_range(21, 60);
        pick = $urandom_range(0, 9);
        temp = (pick == 0) ? 16'h8000 : (pick == 1) ? 16'h7FFF : 16'($urandom);
        pick = $urandom_range(0, 9);
        hum  = (pick == 0) ? 16'd10000 : (pick == 1) ? 16'd10001 :
               (pick == 2) ? 16'($urandom) : 16'($urandom_range(0, 10000));
        pick = $urandom_range(0, 9);
        sel  = (pick < 8) ? 8'($urandom_range(0, 1)) : 8'($urandom);
        pick = $urandom_range(0, 9);
        batt = (pick == 0) ? 8'd100 : (pick == 1) ? 8'd101 :
               (pick == 2) ? 8'($urandom) : 8'($urandom_range(0, 100));
        pick = $urandom_range(0, 9);
        stat = (pick < 4) ? STATUS_A : (pick < 8) ? STATUS_B : 8'($urandom);
        adv_bytes.push_back(8'(plen + 1));
        adv_bytes.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : MFR_TYPE);
        for (int i = 0; i < plen; i++) begin
          b = 8'($urandom);
          if (i < 9) begin
            case (4'(i))
              POS_TEMP_LO: b = temp[7:0];
              POS_TEMP_HI: b = temp[15:8];
              POS_HUM_LO:  b = hum[7:0];
              POS_HUM_HI:  b = hum[15:8];
              POS_SEL:     b = sel;
              POS_BATT:    b = batt;
              POS_STATUS:  b = stat;
              default: ;
            endcase
          end
          adv_bytes.push_back(b);
        end
      end else begin
        // some other structure type
        plen = $urandom_range(0, 12);
        adv_bytes.push_back(8'(plen + 1));
        adv_bytes.push_back(8'($urandom));
        repeat (plen) adv_bytes.push_back(8'($urandom));
      end
    end
    if (kind < 20 && adv_bytes.size() > 1) begin
      // cut the advertisement short
      keep = $urandom_range(1, adv_bytes.size() - 1);
      while (adv_bytes.size() > keep) void'(adv_bytes.pop_back());
    end else if (kind < 30) begin
      // zero length stop followed by junk
      adv_bytes.push_back(8'd0);
      repeat ($urandom_range(0, 6)) adv_bytes.push_back(8'($urandom));
    end
  endtask

  initial begin
    adv_item_t it;
    int        ad_idx;

    // zero length as the only byte, nonzero length as the only byte,
    // record with extremes and a tenth payload byte then ignored trailing length,
    // truncated record, zero length stop followed by junk
    dir_rows = '{
      {8'h00, 1'b1},
      {8'h03, 1'b1},
      {8'h0B, 1'b0}, {8'hFF, 1'b0}, {8'h00, 1'b0}, {8'h80, 1'b0}, {8'h10, 1'b0},
      {8'h27, 1'b0}, {8'h01, 1'b0}, {8'h5A, 1'b0}, {8'hA5, 1'b0}, {8'h64, 1'b0},
      {8'h08, 1'b0}, {8'hC3, 1'b0}, {8'h05, 1'b1},
      {8'h0A, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b0}, {8'h7F, 1'b0}, {8'h00, 1'b0},
      {8'h00, 1'b0}, {8'h00, 1'b1},
      {8'h02, 1'b0}, {8'h01, 1'b0}, {8'h06, 1'b0}, {8'h00, 1'b0}, {8'hFF, 1'b1}
    };
    dir_want[0] = report_of(OUT_NONE, 1'b0, 16'd0, 14'd0, 7'd0);
    dir_want[1] = report_of(OUT_MALFORMED, 1'b0, 16'd0, 14'd0, 7'd0);
    dir_want[2] = report_of(OUT_OK, 1'b1, 16'h8000, 14'd10000, 7'd100);
    dir_want[3] = report_of(OUT_MALFORMED, 1'b0, 16'd0, 14'd0, 7'd0);
    dir_want[4] = report_of(OUT_NONE, 1'b0, 16'd0, 14'd0, 7'd0);
    clear_parser();

    // synchronous reset
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    ad_idx = 0;
    for (int i = 0; i < DIR_N; i++) begin
      it = dir_rows[i];
      push_byte(it, draw_gap(), it.final_byte, dir_want[ad_idx]);
      if (it.final_byte) ad_idx++;
    end

    // random traffic with random idling on both sides
    while (bytes_sent < 600) begin
      build_advert();
      send_advert();
    end

    // drain, then hold the receiver off while short adverts back up the block
    adv_valid = 1'b0;
    while (report_q.size() != 0) @(negedge clk);
    hold_len = 400;
    hold_seq++;
    tx_calm = 1'b1;
    repeat (6) begin
      adv_bytes.delete();
      repeat ($urandom_range(1, 3)) adv_bytes.push_back(8'($urandom));
      send_advert();
    end

    // back-to-back stretch
    rx_calm = 1'b1;
    while (bytes_sent < 1100) begin
      build_advert();
      send_advert();
    end

    // random idling again
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    while (bytes_sent < 1800) begin
      build_advert();
      send_advert();
    end
    adv_valid = 1'b0;

    // wait for outstanding reports, then idle briefly before the summary
    while (report_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d bytes in %0d advertisements under random and held-off flow control",
             bytes_sent, n_ok + n_malformed + n_none);
    $display("reports: %0d recognized, %0d malformed, %0d without a record, %0d mismatches",
             n_ok, n_malformed, n_none, fault_cnt);
    if (fault_cnt == 0 && report_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/blasp_pkg.sv
rtl/blasp_parse.sv
rtl/blasp_out.sv
rtl/ble_adv_sensor_record_parser_unit.sv
tb/sv/tb.sv
